// ===== rtl/sorted_table_binary_search_assert.svh =====
// Assertion helpers for the sorted table search block.
// Each macro expects a clock named clock and a reset named reset in scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stbs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stbs: next-cycle check failed");

`endif

// ===== rtl/stbs_pkg.sv =====
package stbs_pkg;

   localparam int KEY_W = 32;
   localparam int IDX_W = 10;
   localparam int LEN_W = 11;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

endpackage

// ===== rtl/stbs_req_if.sv =====
interface stbs_req_if;
   import stbs_pkg::*;

   logic                     valid;
   logic                     ready;
   cmd_type                  command;
   logic [IDX_W-1:0]         write_index;
   logic signed [KEY_W-1:0]  write_data;
   logic signed [KEY_W-1:0]  search_key;

   modport source (
      output valid, command, write_index, write_data, search_key,
      input  ready
   );

   modport sink (
      input  valid, command, write_index, write_data, search_key,
      output ready
   );

endinterface

// ===== rtl/stbs_rsp_if.sv =====
interface stbs_rsp_if;
   import stbs_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [IDX_W-1:0] match_index;

   modport source (
      output valid, found, match_index,
      input  ready
   );

   modport sink (
      input  valid, found, match_index,
      output ready
   );

endinterface

// ===== rtl/sorted_table_binary_search.sv =====
// Write requests are taken while the block is idle and give no response.
// A search over n entries makes one probe per cycle, at most floor(log2(n)) + 1
// probes (11 for 1024 entries); an empty table needs no probe.
// The probe rate is set by the single table read port and the shared compare/update path.
// A new request is accepted only once the search result is in the response register.
// Synchronous active-high reset clears the sequencer, response valid and table_length.
module sorted_table_binary_search #(
   parameter int DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [stbs_pkg::LEN_W-1:0]   csr_write_data,
   stbs_req_if.sink                     req_chan,
   stbs_rsp_if.source                   rsp_chan
);
   import stbs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int WW = (LW > LEN_W) ? LW : LEN_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_HOLD
   } state_type;

   state_type                state_ff;
   logic [LEN_W-1:0]         table_length_ff;
   logic [WW-1:0]            lo_ff;
   logic [WW-1:0]            hix_ff;
   logic [AW-1:0]            mid_ff;
   logic signed [KEY_W-1:0]  key_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic                     hold_found_ff;
   logic [IDX_W-1:0]         hold_index_ff;

   logic [WW-1:0]            len_w;
   logic [WW-1:0]            lo_in;
   logic [WW-1:0]            hix_in;
   logic [AW-1:0]            mid_in;
   logic [WW-1:0]            mid_wide;
   logic [WW-1:0]            widx_wide;
   logic [KEY_W-1:0]         entry;
   logic                     entry_eq;
   logic                     entry_lt;
   logic                     ram_we;
   logic                     req_take;
   logic                     out_free;
   logic                     probe_hit;

   // Midpoint of the half-open range [a, b); meaningful only when a < b.
   function automatic logic [AW-1:0] mid_of(input logic [WW-1:0] a, input logic [WW-1:0] b);
      logic [WW:0] s;
      s = {1'b0, a} + {1'b0, b} - (WW + 1)'(1);
      return s[AW:1];
   endfunction

   assign req_take  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign widx_wide = WW'(req_chan.write_index);
   assign ram_we    = req_take && (req_chan.command == CMD_WRITE) && (widx_wide < WW'(DEPTH));
   assign mid_wide  = WW'(mid_ff);
   assign entry_eq  = (entry == key_ff);
   assign entry_lt  = ($signed(entry) < key_ff);
   assign probe_hit = (state_ff == S_PROBE) && (lo_ff < hix_ff) && entry_eq;

   always_comb begin
      len_w = WW'(table_length_ff);
      if (len_w > WW'(DEPTH)) begin
         len_w = WW'(DEPTH);
      end
   end

   // The search keeps a half-open range [lo, hix); high in the usual form is hix - 1.
   always_comb begin
      lo_in  = lo_ff;
      hix_in = hix_ff;
      if (state_ff == S_IDLE) begin
         lo_in  = '0;
         hix_in = len_w;
      end else if (entry_lt) begin
         lo_in = mid_wide + WW'(1);
      end else begin
         hix_in = mid_wide;
      end
      mid_in = mid_of(lo_in, hix_in);
   end

   stbs_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (widx_wide[AW-1:0]),
      .wr_data (req_chan.write_data),
      .rd_addr (mid_in),
      .rd_data (entry)
   );

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.match_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         table_length_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            table_length_ff <= csr_write_data;
         end
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take && (req_chan.command == CMD_SEARCH)) begin
                  lo_ff    <= lo_in;
                  hix_ff   <= hix_in;
                  mid_ff   <= mid_in;
                  key_ff   <= req_chan.search_key;
                  state_ff <= S_PROBE;
               end
            end
            S_PROBE: begin
               if (!(lo_ff < hix_ff) || entry_eq || !(lo_in < hix_in)) begin
                  // Empty range on entry, a hit, or the range closed after this probe.
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_found_ff <= (lo_ff < hix_ff) && entry_eq;
                     rsp_index_ff <= ((lo_ff < hix_ff) && entry_eq) ?
                                     mid_wide[IDX_W-1:0] : '0;
                     state_ff     <= S_IDLE;
                  end else begin
                     hold_found_ff <= (lo_ff < hix_ff) && entry_eq;
                     hold_index_ff <= ((lo_ff < hix_ff) && entry_eq) ?
                                      mid_wide[IDX_W-1:0] : '0;
                     state_ff      <= S_HOLD;
                  end
               end else begin
                  lo_ff  <= lo_in;
                  hix_ff <= hix_in;
                  mid_ff <= mid_in;
               end
            end
            S_HOLD: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= hold_found_ff;
                  rsp_index_ff <= hold_index_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`include "sorted_table_binary_search_assert.svh"

   `STBS_ASSERT_SAME(a_probe_range, state_ff == S_PROBE, (lo_ff <= hix_ff) && (hix_ff <= WW'(DEPTH)))
   `STBS_ASSERT_SAME(a_write_when_idle, ram_we, state_ff == S_IDLE)
   `STBS_ASSERT_SAME(a_hold_has_pending, state_ff == S_HOLD, rsp_valid_ff)
   `STBS_ASSERT_NEXT(a_hit_reported, probe_hit && out_free, rsp_valid_ff && rsp_found_ff)

endmodule

// ===== rtl/stbs_ram.sv =====
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import stbs_pkg::*;

   localparam int TABLE_DEPTH = 1024;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 45;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] match_index;
   } search_result_type;

   class search_scoreboard;
      logic signed [KEY_W-1:0] entries [TABLE_DEPTH];
      logic [LEN_W-1:0]        table_length;
      search_result_type       awaited_results [$];
      int                      error_count;

      function new();
         table_length = '0;
         error_count = 0;
      endfunction

      function int effective_length();
         return (table_length > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_length);
      endfunction

      function search_result_type search_table(logic signed [KEY_W-1:0] key);
         search_result_type res;
         int lo;
         int hi;
         int mid;
         res = '0;
         lo = 0;
         hi = effective_length() - 1;
         while (lo <= hi && !res.found) begin
            mid = (lo + hi) / 2;
            if (entries[mid] == key) begin
               res.found = 1'b1;
               res.match_index = mid[IDX_W-1:0];
            end else if (entries[mid] < key) begin
               lo = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end
         return res;
      endfunction

      function void note_request(cmd_type command, logic [IDX_W-1:0] index,
                                 logic signed [KEY_W-1:0] data,
                                 logic signed [KEY_W-1:0] key);
         if (command == CMD_WRITE) begin
            entries[index] = data;
         end else begin
            awaited_results.push_back(search_table(key));
         end
      endfunction

      function void check_response(logic found, logic [IDX_W-1:0] match_index);
         search_result_type want;
         if (awaited_results.size() == 0) begin
            $error("response with no search outstanding: found %0d match_index %0d",
                   found, match_index);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, found);
               error_count++;
            end
            if (match_index !== want.match_index) begin
               $error("match_index: expected %0d, actual %0d", want.match_index, match_index);
               error_count++;
            end
         end
      endfunction

      function bit busy();
         return awaited_results.size() != 0;
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [LEN_W-1:0] csr_write_data;
   bit               burst_mode;
   int unsigned      cycle_count = 0;
   search_scoreboard board;

   stbs_req_if req_chan ();
   stbs_rsp_if rsp_chan ();

   sorted_table_binary_search #(
      .DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         board.check_response(rsp_chan.found, rsp_chan.match_index);
      end
      if (!reset && req_chan.valid && req_chan.ready) begin
         board.note_request(req_chan.command, req_chan.write_index, req_chan.write_data,
                            req_chan.search_key);
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_table_binary_search regression: fail");
      $finish;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(8, 40);
      end
   endfunction

   // The response side holds ready for random stretches, some followed by stalls of random length.
   initial begin : rsp_throttle
      int stall;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic send_request(cmd_type command, logic [IDX_W-1:0] index,
                               logic signed [KEY_W-1:0] data,
                               logic signed [KEY_W-1:0] key);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.command <= command;
      req_chan.write_index <= index;
      req_chan.write_data <= data;
      req_chan.search_key <= key;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // Valid stays high when the next request follows with no gap.
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_entry(logic [IDX_W-1:0] index, logic signed [KEY_W-1:0] data);
      send_request(CMD_WRITE, index, data, $urandom);
   endtask

   task automatic search(logic signed [KEY_W-1:0] key);
      send_request(CMD_SEARCH, IDX_W'($urandom), $urandom, key);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.busy()) @(posedge clock);
      // A write or the tail of a search may still be in flight.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_length(int len);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= len[LEN_W-1:0];
      @(posedge clock);
      board.table_length = len[LEN_W-1:0];
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(int len);
      int n;
      int i;
      int l;
      int r;
      logic signed [KEY_W-1:0] key;
      logic signed [KEY_W-1:0] data;
      logic [IDX_W-1:0] idx;
      longint lo;
      longint hi;
      set_length(len);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
         l = board.effective_length();
         r = $urandom_range(0, 99);
         if (r < 70) begin
            // Most keys come from the table or sit right next to an entry.
            r = $urandom_range(0, 99);
            i = (l > 0) ? $urandom_range(0, l - 1) : 0;
            if (l == 0 || r >= 85) begin
               key = $urandom;
            end else if (r < 55) begin
               key = board.entries[i];
            end else if (r < 75) begin
               key = (r % 2) ? board.entries[i] + 32'sd1 : board.entries[i] - 32'sd1;
            end else begin
               case (r % 4)
                  0: key = KEY_MIN;
                  1: key = KEY_MAX;
                  2: key = '0;
                  default: key = -32'sd1;
               endcase
            end
            search(key);
         end else begin
            if (l > 0 && $urandom_range(0, 3) != 0) begin
               idx = IDX_W'($urandom_range(0, l - 1));
            end else begin
               idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
            end
            // Most writes keep the order between the neighbors; the rest write a random value.
            lo = (idx == 0) ? KEY_MIN : board.entries[idx - 1];
            hi = (idx == TABLE_DEPTH - 1) ? KEY_MAX : board.entries[idx + 1];
            if ($urandom_range(0, 99) < 85 && lo <= hi) begin
               data = KEY_W'(lo + (longint'($urandom) % (hi - lo + 1)));
            end else begin
               data = $urandom;
            end
            write_entry(idx, data);
         end
         if ($urandom_range(0, 49) == 0) begin
            drain();
         end
      end
   endtask

   initial begin : stimulus
      int i;
      longint acc;
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_WRITE;
      req_chan.write_index = '0;
      req_chan.write_data = '0;
      req_chan.search_key = '0;
      burst_mode = 1'b0;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The length is zero out of reset, so the table is empty.
      search('0);
      write_entry(0, KEY_MIN);
      write_entry(1, -32'sd5);
      write_entry(2, '0);
      write_entry(3, 32'sd7);
      write_entry(4, KEY_MAX);
      write_entry(IDX_W'(TABLE_DEPTH - 1), KEY_MAX);
      set_length(5);
      search(KEY_MIN);
      search(-32'sd5);
      search('0);
      search(32'sd7);
      search(KEY_MAX);
      search(32'sd3);
      search(32'sd100);
      search(-32'sd100);
      set_length(1);
      search(KEY_MIN);
      search('0);
      set_length(0);
      search(KEY_MIN);
      // Break the order and check that the probe path is still followed.
      write_entry(2, 32'sd1000);
      set_length(5);
      search(32'sd1000);
      search(32'sd7);

      // Load the whole table in ascending order, with some repeated values.
      drain();
      acc = longint'(KEY_MIN) + $urandom_range(0, 1000);
      for (i = 0; i < TABLE_DEPTH; i++) begin
         write_entry(i[IDX_W-1:0], acc[KEY_W-1:0]);
         if ($urandom_range(0, 7) != 0) begin
            acc = acc + $urandom_range(1, 8_000_000);
         end
         if (acc > KEY_MAX) begin
            acc = KEY_MAX;
         end
      end

      run_phase(TABLE_DEPTH);
      run_phase(2047);
      run_phase(1);
      run_phase(2);
      run_phase(TABLE_DEPTH - 1);
      run_phase(TABLE_DEPTH + 1);
      run_phase(3);
      run_phase($urandom_range(4, TABLE_DEPTH - 2));
      run_phase(0);
      run_phase($urandom_range(TABLE_DEPTH + 2, 2046));
      run_phase(TABLE_DEPTH);

      drain();
      if (board.error_count == 0) begin
         $display("sorted_table_binary_search regression: pass");
      end else begin
         $display("sorted_table_binary_search regression: fail");
      end
      $finish;
   end

endmodule
